>>> src/rsi_pkg.sv
// Shared widths, constants and sideband types for the ray-sphere intersection pipeline.
// No dependencies; used by rsi_isqrt, rsi_divide and ray_sphere_intersect.
package rsi_pkg;

   localparam int CW = 32;              // coordinate width, Q.FB signed
   localparam int FB = 16;              // fraction bits

   localparam int VW  = CW + 1;         // origin minus centre
   localparam int AW  = 2 * CW;         // a = D.D, unsigned
   localparam int PDV = 2 * CW + 1;     // one D*V product, signed
   localparam int PVV = 2 * CW + 2;     // one V*V product, signed
   localparam int PRR = 2 * CW - 2;     // r*r, unsigned
   localparam int DVW = 2 * CW + 2;     // D.V, signed
   localparam int CCW = 2 * CW + 3;     // c = V.V - r*r, signed
   localparam int DMW = 2 * CW + 1;     // |D.V|
   localparam int CMW = 2 * CW + 2;     // |c|

   localparam int DL = (DMW + 1) / 2;   // split of |D.V| for squaring
   localparam int DH = DMW - DL;
   localparam int AL = AW / 2;          // split of a
   localparam int AH = AW - AL;
   localparam int CL = (CMW + 1) / 2;   // split of |c|
   localparam int CH = CMW - CL;

   localparam int SQW = 2 * DMW;        // (D.V)^2
   localparam int ACW = AW + CMW;       // a*|c|
   localparam int DPW = 4 * CW + 3;     // (D.V)^2 - a*c, signed

   localparam int DW  = 4 * CW;         // discriminant when not negative
   localparam int SW  = 2 * CW;         // its square root
   localparam int NSQ = DW / 2;         // square root steps

   localparam int BW  = 2 * CW + 3;     // b = 2 D.V, signed
   localparam int NW  = BW + 1;         // -b -/+ s, signed
   localparam int NUW = NW - 1 + FB;    // positive numerator scaled by FB
   localparam int RW  = (NUW > AW + CW) ? NUW : AW + CW;  // divider remainder
   localparam int NQ  = CW - 1;         // quotient bits = distance width

   localparam logic [NQ-1:0] DMAX = {NQ{1'b1}};

   typedef struct packed {
      logic                 dead;       // zero direction or negative discriminant
      logic [AW-1:0]        a;
      logic signed [BW-1:0] b;
   } sq_side_type;

   typedef struct packed {
      logic hit;
      logic ovf;
   } div_side_type;

endpackage

>>> src/rsi_isqrt.sv
// Pipelined floor square root, one result bit per register stage.
// Depends on rsi_pkg for widths and the sideband type.
module rsi_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [rsi_pkg::DW-1:0]      in_num,
   input  rsi_pkg::sq_side_type        in_side,
   output logic                        out_valid,
   output logic [rsi_pkg::SW-1:0]      out_root,
   output rsi_pkg::sq_side_type        out_side
);
   localparam int N  = rsi_pkg::NSQ;
   localparam int DW = rsi_pkg::DW;
   localparam logic [DW-1:0] ONE = {{(DW-1){1'b0}}, 1'b1};

   logic [N-1:0]         vld_ff;
   logic [N-1:0]         vld_in;
   logic [DW-1:0]        num_ff  [N];
   logic [DW-1:0]        num_in  [N];
   logic [DW-1:0]        res_ff  [N];
   logic [DW-1:0]        res_in  [N];
   rsi_pkg::sq_side_type side_ff [N];
   rsi_pkg::sq_side_type side_in [N];

   always_comb begin
      logic [DW-1:0] nsrc;
      logic [DW-1:0] rsrc;
      logic [DW-1:0] bitk;
      logic [DW-1:0] trial;
      logic          ge;
      for (int i = 0; i < N; i++) begin
         if (i == 0) begin
            vld_in[i]  = in_valid;
            nsrc       = in_num;
            rsrc       = '0;
            side_in[i] = in_side;
         end else begin
            vld_in[i]  = vld_ff[i-1];
            nsrc       = num_ff[i-1];
            rsrc       = res_ff[i-1];
            side_in[i] = side_ff[i-1];
         end
         bitk  = ONE << (DW - 2 - 2 * i);
         trial = rsrc | bitk;
         ge    = nsrc >= trial;
         num_in[i] = ge ? nsrc - trial : nsrc;
         res_in[i] = ge ? ((rsrc >> 1) | bitk) : (rsrc >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < N; i++) begin
            num_ff[i]  <= num_in[i];
            res_ff[i]  <= res_in[i];
            side_ff[i] <= side_in[i];
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_root  = res_ff[N-1][rsi_pkg::SW-1:0];
   assign out_side  = side_ff[N-1];

endmodule

>>> src/rsi_divide.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on rsi_pkg; the caller guarantees the quotient fits NQ bits.
module rsi_divide (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [rsi_pkg::RW-1:0]        in_num,
   input  logic [rsi_pkg::AW:0]          in_den,
   input  rsi_pkg::div_side_type         in_side,
   output logic                          out_valid,
   output logic [rsi_pkg::NQ-1:0]        out_quot,
   output rsi_pkg::div_side_type         out_side
);
   localparam int N  = rsi_pkg::NQ;
   localparam int RW = rsi_pkg::RW;
   localparam logic [N-1:0] QONE = {{(N-1){1'b0}}, 1'b1};

   logic [N-1:0]          vld_ff;
   logic [N-1:0]          vld_in;
   logic [RW-1:0]         rem_ff  [N];
   logic [RW-1:0]         rem_in  [N];
   logic [RW-1:0]         den_ff  [N];
   logic [RW-1:0]         den_in  [N];
   logic [N-1:0]          q_ff    [N];
   logic [N-1:0]          q_in    [N];
   rsi_pkg::div_side_type side_ff [N];
   rsi_pkg::div_side_type side_in [N];

   always_comb begin
      logic [RW-1:0] rsrc;
      logic [N-1:0]  qsrc;
      logic [RW-1:0] step;
      logic          ge;
      for (int i = 0; i < N; i++) begin
         if (i == 0) begin
            vld_in[i]  = in_valid;
            rsrc       = in_num;
            den_in[i]  = RW'(in_den);
            qsrc       = '0;
            side_in[i] = in_side;
         end else begin
            vld_in[i]  = vld_ff[i-1];
            rsrc       = rem_ff[i-1];
            den_in[i]  = den_ff[i-1];
            qsrc       = q_ff[i-1];
            side_in[i] = side_ff[i-1];
         end
         step      = den_in[i] << (N - 1 - i);
         ge        = rsrc >= step;
         rem_in[i] = ge ? rsrc - step : rsrc;
         q_in[i]   = ge ? (qsrc | (QONE << (N - 1 - i))) : qsrc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < N; i++) begin
            rem_ff[i]  <= rem_in[i];
            den_ff[i]  <= den_in[i];
            q_ff[i]    <= q_in[i];
            side_ff[i] <= side_in[i];
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_quot  = q_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

>>> src/ray_sphere_intersect.sv
// Ray-sphere intersection, top level: operand front end, root selection and output register.
// Depends on rsi_pkg, rsi_isqrt and rsi_divide.
//
// Usage:
//   Input channel req_*: one beat carries a ray origin, a ray direction, a sphere centre
//   (signed Q16.16) and a radius (unsigned Q15.16). Result channel rsp_*: one beat per
//   input beat, in order, with rsp_hit and rsp_distance, the nearest positive root t in
//   unsigned Q15.16, saturated at the largest 31-bit value, and 0 when there is no hit. A zero
//   direction or a negative discriminant gives no hit.
// Throughput: one beat per cycle; a new beat enters on every cycle the output is free.
// Pipeline: 7 front-end stages (difference, products, dot sums, magnitudes, partial
//   products, partial sums, discriminant), NSQ = 64 square root stages, 3 root-selection
//   stages (numerators, positivity and choice, overflow test), NQ = 31 divider stages and
//   the output register. The square root, one bit a stage over the 128-bit discriminant,
//   sets most of that depth.
// Stall: the whole pipeline advances together; while rsp_valid is high and rsp_ready low,
//   every stage holds and req_ready drops, so nothing is lost or repeated.
// Reset: synchronous, active high; drop all valid bits, the pipeline comes up empty.
module ray_sphere_intersect (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [rsi_pkg::CW-1:0]     req_origin_x,
   input  logic signed [rsi_pkg::CW-1:0]     req_origin_y,
   input  logic signed [rsi_pkg::CW-1:0]     req_origin_z,
   input  logic signed [rsi_pkg::CW-1:0]     req_dir_x,
   input  logic signed [rsi_pkg::CW-1:0]     req_dir_y,
   input  logic signed [rsi_pkg::CW-1:0]     req_dir_z,
   input  logic signed [rsi_pkg::CW-1:0]     req_center_x,
   input  logic signed [rsi_pkg::CW-1:0]     req_center_y,
   input  logic signed [rsi_pkg::CW-1:0]     req_center_z,
   input  logic [rsi_pkg::CW-2:0]            req_radius,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic [rsi_pkg::NQ-1:0]            rsp_distance
);
   localparam int CW  = rsi_pkg::CW;
   localparam int FB  = rsi_pkg::FB;
   localparam int VW  = rsi_pkg::VW;
   localparam int AW  = rsi_pkg::AW;
   localparam int PDV = rsi_pkg::PDV;
   localparam int PVV = rsi_pkg::PVV;
   localparam int PRR = rsi_pkg::PRR;
   localparam int DVW = rsi_pkg::DVW;
   localparam int CCW = rsi_pkg::CCW;
   localparam int DMW = rsi_pkg::DMW;
   localparam int CMW = rsi_pkg::CMW;
   localparam int DL  = rsi_pkg::DL;
   localparam int DH  = rsi_pkg::DH;
   localparam int AL  = rsi_pkg::AL;
   localparam int AH  = rsi_pkg::AH;
   localparam int CL  = rsi_pkg::CL;
   localparam int CH  = rsi_pkg::CH;
   localparam int SQW = rsi_pkg::SQW;
   localparam int ACW = rsi_pkg::ACW;
   localparam int DPW = rsi_pkg::DPW;
   localparam int DW  = rsi_pkg::DW;
   localparam int SW  = rsi_pkg::SW;
   localparam int NW  = rsi_pkg::NW;
   localparam int NUW = rsi_pkg::NUW;
   localparam int RW  = rsi_pkg::RW;
   localparam int NQ  = rsi_pkg::NQ;

   // global advance: move when the output register is empty or being drained
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   logic [7:1] vld_ff;
   logic [7:1] vld_in;

   // stage 1: V = O - C
   logic signed [CW-1:0] org_w [3];
   logic signed [CW-1:0] dir_w [3];
   logic signed [CW-1:0] cen_w [3];
   logic signed [VW-1:0] v1_ff [3];
   logic signed [VW-1:0] v1_in [3];
   logic signed [CW-1:0] d1_ff [3];
   logic [CW-2:0]        r1_ff;

   // stage 2: products
   logic [AW-1:0]         dd2_ff [3];
   logic [AW-1:0]         dd2_in [3];
   logic signed [PDV-1:0] dv2_ff [3];
   logic signed [PDV-1:0] dv2_in [3];
   logic signed [PVV-1:0] vv2_ff [3];
   logic signed [PVV-1:0] vv2_in [3];
   logic [PRR-1:0]        rr2_ff;

   // stage 3: dot sums
   logic [AW-1:0]         a3_ff;
   logic signed [DVW-1:0] dv3_ff;
   logic signed [CCW-1:0] c3_ff;

   // stage 4: magnitudes
   logic [DMW-1:0]        dvm4_ff;
   logic [CMW-1:0]        cm4_ff;
   logic                  cneg4_ff;
   rsi_pkg::sq_side_type  side4_ff;

   // stage 5: partial products
   logic [2*DH-1:0]       p_dhh5_ff;
   logic [DH+DL-1:0]      p_dhl5_ff;
   logic [2*DL-1:0]       p_dll5_ff;
   logic [AH+CH-1:0]      p_ahch5_ff;
   logic [AH+CL-1:0]      p_ahcl5_ff;
   logic [AL+CH-1:0]      p_alch5_ff;
   logic [AL+CL-1:0]      p_alcl5_ff;
   logic                  cneg5_ff;
   rsi_pkg::sq_side_type  side5_ff;

   // stage 6: partial sums
   logic [SQW-1:0]        sq6_ff;
   logic [ACW-1:0]        ac6_ff;
   logic                  cneg6_ff;
   rsi_pkg::sq_side_type  side6_ff;

   // stage 7: discriminant
   logic signed [DPW-1:0] dp7_w;
   logic [DW-1:0]         disc7_ff;
   rsi_pkg::sq_side_type  side7_ff;

   assign org_w[0] = req_origin_x;
   assign org_w[1] = req_origin_y;
   assign org_w[2] = req_origin_z;
   assign dir_w[0] = req_dir_x;
   assign dir_w[1] = req_dir_y;
   assign dir_w[2] = req_dir_z;
   assign cen_w[0] = req_center_x;
   assign cen_w[1] = req_center_y;
   assign cen_w[2] = req_center_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         v1_in[i]  = VW'(org_w[i]) - VW'(cen_w[i]);
         dd2_in[i] = AW'(AW'(d1_ff[i]) * AW'(d1_ff[i]));
         dv2_in[i] = PDV'(d1_ff[i]) * PDV'(v1_ff[i]);
         vv2_in[i] = PVV'(v1_ff[i]) * PVV'(v1_ff[i]);
      end
   end

   // (D.V)^2 - a*c; c carries its sign separately so the products stay unsigned
   assign dp7_w = cneg6_ff ? DPW'(sq6_ff) + DPW'(ac6_ff) : DPW'(sq6_ff) - DPW'(ac6_ff);

   assign vld_in = {vld_ff[6:1], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // stage 1
         v1_ff <= v1_in;
         d1_ff <= dir_w;
         r1_ff <= req_radius;
         // stage 2
         dd2_ff <= dd2_in;
         dv2_ff <= dv2_in;
         vv2_ff <= vv2_in;
         rr2_ff <= PRR'(r1_ff) * PRR'(r1_ff);
         // stage 3
         a3_ff  <= dd2_ff[0] + dd2_ff[1] + dd2_ff[2];
         dv3_ff <= DVW'(dv2_ff[0]) + DVW'(dv2_ff[1]) + DVW'(dv2_ff[2]);
         c3_ff  <= CCW'(vv2_ff[0]) + CCW'(vv2_ff[1]) + CCW'(vv2_ff[2])
                   - CCW'($signed({1'b0, rr2_ff}));
         // stage 4
         dvm4_ff       <= dv3_ff[DVW-1] ? DMW'(-dv3_ff) : DMW'(dv3_ff);
         cm4_ff        <= c3_ff[CCW-1] ? CMW'(-c3_ff) : CMW'(c3_ff);
         cneg4_ff      <= c3_ff[CCW-1];
         side4_ff.dead <= (a3_ff == '0);
         side4_ff.a    <= a3_ff;
         side4_ff.b    <= {dv3_ff, 1'b0};
         // stage 5
         p_dhh5_ff  <= (2*DH)'(dvm4_ff[DMW-1:DL]) * (2*DH)'(dvm4_ff[DMW-1:DL]);
         p_dhl5_ff  <= (DH+DL)'(dvm4_ff[DMW-1:DL]) * (DH+DL)'(dvm4_ff[DL-1:0]);
         p_dll5_ff  <= (2*DL)'(dvm4_ff[DL-1:0]) * (2*DL)'(dvm4_ff[DL-1:0]);
         p_ahch5_ff <= (AH+CH)'(side4_ff.a[AW-1:AL]) * (AH+CH)'(cm4_ff[CMW-1:CL]);
         p_ahcl5_ff <= (AH+CL)'(side4_ff.a[AW-1:AL]) * (AH+CL)'(cm4_ff[CL-1:0]);
         p_alch5_ff <= (AL+CH)'(side4_ff.a[AL-1:0]) * (AL+CH)'(cm4_ff[CMW-1:CL]);
         p_alcl5_ff <= (AL+CL)'(side4_ff.a[AL-1:0]) * (AL+CL)'(cm4_ff[CL-1:0]);
         cneg5_ff   <= cneg4_ff;
         side5_ff   <= side4_ff;
         // stage 6
         sq6_ff   <= (SQW'(p_dhh5_ff) << (2 * DL)) + (SQW'(p_dhl5_ff) << (DL + 1))
                     + SQW'(p_dll5_ff);
         ac6_ff   <= (ACW'(p_ahch5_ff) << (AL + CL)) + (ACW'(p_ahcl5_ff) << AL)
                     + (ACW'(p_alch5_ff) << CL) + ACW'(p_alcl5_ff);
         cneg6_ff <= cneg5_ff;
         side6_ff <= side5_ff;
         // stage 7: disc = 4 * dp; when not negative it fits DW bits
         disc7_ff      <= {dp7_w[DW-3:0], 2'b00};
         side7_ff.dead <= side6_ff.dead || dp7_w[DPW-1];
         side7_ff.a    <= side6_ff.a;
         side7_ff.b    <= side6_ff.b;
      end
   end

   // square root of the discriminant
   logic                 sq_valid;
   logic [SW-1:0]        sq_root;
   rsi_pkg::sq_side_type sq_side;

   rsi_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vld_ff[7]),
      .in_num    (disc7_ff),
      .in_side   (side7_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // root selection: numerators, positivity, overflow test
   logic [3:1]            sel_vld_ff;
   logic signed [NW-1:0]  n1_8_ff;
   logic signed [NW-1:0]  n2_8_ff;
   logic [AW:0]           den8_ff;
   logic                  dead8_ff;
   logic [NUW-1:0]        big1_w;
   logic [NUW-1:0]        big2_w;
   logic                  pos1_w;
   logic                  pos2_w;
   logic [RW-1:0]         num9_ff;
   logic [AW:0]           den9_ff;
   logic                  hit9_ff;
   logic [RW-1:0]         num10_ff;
   logic [AW:0]           den10_ff;
   rsi_pkg::div_side_type side10_ff;

   assign big1_w = {n1_8_ff[NW-2:0], {FB{1'b0}}};
   assign big2_w = {n2_8_ff[NW-2:0], {FB{1'b0}}};
   // a root counts only when its truncated quotient is at least one LSB
   assign pos1_w = !n1_8_ff[NW-1] && (big1_w >= NUW'(den8_ff));
   assign pos2_w = !n2_8_ff[NW-1] && (big2_w >= NUW'(den8_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_vld_ff <= '0;
      end else if (en) begin
         sel_vld_ff <= {sel_vld_ff[2:1], sq_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n1_8_ff  <= -NW'(sq_side.b) - NW'(sq_root);
         n2_8_ff  <= NW'(sq_root) - NW'(sq_side.b);
         den8_ff  <= {sq_side.a, 1'b0};
         dead8_ff <= sq_side.dead;

         num9_ff <= pos1_w ? RW'(big1_w) : RW'(big2_w);
         den9_ff <= den8_ff;
         hit9_ff <= !dead8_ff && (pos1_w || pos2_w);

         num10_ff      <= num9_ff;
         den10_ff      <= den9_ff;
         side10_ff.hit <= hit9_ff;
         side10_ff.ovf <= num9_ff >= (RW'(den9_ff) << NQ);
      end
   end

   // quotient, valid only when the overflow test failed
   logic                  dv_valid;
   logic [NQ-1:0]         dv_quot;
   rsi_pkg::div_side_type dv_side;

   rsi_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sel_vld_ff[3]),
      .in_num    (num10_ff),
      .in_den    (den10_ff),
      .in_side   (side10_ff),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_side  (dv_side)
   );

   // output register
   logic          rsp_valid_ff;
   logic          rsp_hit_ff;
   logic [NQ-1:0] rsp_distance_ff;
   logic [NQ-1:0] rsp_distance_in;

   assign rsp_distance_in = !dv_side.hit ? '0 : (dv_side.ovf ? rsi_pkg::DMAX : dv_quot);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_hit_ff      <= dv_side.hit;
         rsp_distance_ff <= rsp_distance_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_distance = rsp_distance_ff;

endmodule

>>> tb/ray_sphere_intersect_tb.sv
// Self-checking testbench for ray_sphere_intersect: drives ray/sphere beats, predicts the
// nearest positive root with wide exact integer arithmetic and checks every result beat.
// Depends on rsi_pkg and the ray_sphere_intersect RTL.
module ray_sphere_intersect_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = rsi_pkg::CW;
   localparam int FB = rsi_pkg::FB;
   localparam int NQ = rsi_pkg::NQ;
   localparam logic [NQ-1:0] DMAX = rsi_pkg::DMAX;

   localparam int XW = 200;          // wide enough that no intermediate can wrap
   localparam int LIMIT = 2000000;   // cycle budget for the whole run

   typedef struct {
      logic signed [CW-1:0] ox, oy, oz, dx, dy, dz, cx, cy, cz;
      logic [CW-2:0]        r;
   } ray_item_type;

   typedef struct {
      logic          hit;
      logic [NQ-1:0] distance;
   } hit_result_type;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, rsp_hit;
   logic signed [CW-1:0] req_origin_x, req_origin_y, req_origin_z;
   logic signed [CW-1:0] req_dir_x, req_dir_y, req_dir_z;
   logic signed [CW-1:0] req_center_x, req_center_y, req_center_z;
   logic [CW-2:0] req_radius;
   logic [NQ-1:0] rsp_distance;

   ray_item_type   pending_rays[$];
   hit_result_type expected_hits[$];
   int errors = 0;
   int beats_sent = 0;
   int total_rays = 0;
   int cycles = 0;
   bit quiet = 0;

   ray_sphere_intersect i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_origin_x(req_origin_x), .req_origin_y(req_origin_y), .req_origin_z(req_origin_z),
      .req_dir_x(req_dir_x), .req_dir_y(req_dir_y), .req_dir_z(req_dir_z),
      .req_center_x(req_center_x), .req_center_y(req_center_y),
      .req_center_z(req_center_z), .req_radius(req_radius),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_hit(rsp_hit), .rsp_distance(rsp_distance)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Floor square root, one result bit per pair of input bits.
   function automatic logic [XW-1:0] floor_sqrt(logic [XW-1:0] v);
      logic [XW-1:0] res, trial;
      res = '0;
      for (int k = XW - 2; k >= 0; k -= 2) begin
         trial = res | ({{(XW-1){1'b0}}, 1'b1} << k);
         if (v >= trial) begin
            v   = v - trial;
            res = (res >> 1) | ({{(XW-1){1'b0}}, 1'b1} << k);
         end else begin
            res = res >> 1;
         end
      end
      return res;
   endfunction

   // Q.FB quotient of a root numerator; zero when the numerator is not positive.
   function automatic logic [XW-1:0] root_quotient(logic signed [XW-1:0] n,
                                                    logic [XW-1:0] den);
      logic [XW-1:0] un;
      if (n <= 0) return '0;
      un = n;
      return (un << FB) / den;
   endfunction

   function automatic hit_result_type predict_nearest_hit(ray_item_type it);
      hit_result_type res;
      logic signed [XW-1:0] vx, vy, vz, dx, dy, dz, rr, a, b, c, disc, s, nb;
      logic [XW-1:0] q;
      res.hit      = 0;
      res.distance = '0;
      dx = it.dx; dy = it.dy; dz = it.dz;
      vx = XW'(it.ox) - XW'(it.cx);
      vy = XW'(it.oy) - XW'(it.cy);
      vz = XW'(it.oz) - XW'(it.cz);
      rr = {{(XW-CW+1){1'b0}}, it.r};
      a  = dx * dx + dy * dy + dz * dz;
      if (a == 0) return res;
      b    = 2 * (dx * vx + dy * vy + dz * vz);
      c    = vx * vx + vy * vy + vz * vz - rr * rr;
      disc = b * b - 4 * a * c;
      if (disc < 0) return res;
      s  = floor_sqrt(disc);
      nb = -b;
      q  = root_quotient(nb - s, 2 * a);
      if (q == 0) q = root_quotient(nb + s, 2 * a);
      if (q == 0) return res;
      res.hit      = 1;
      res.distance = (q > XW'(DMAX)) ? DMAX : q[NQ-1:0];
      return res;
   endfunction

   function automatic ray_item_type make_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                            int cx, int cy, int cz, int unsigned r);
      ray_item_type it;
      it.ox = ox; it.oy = oy; it.oz = oz;
      it.dx = dx; it.dy = dy; it.dz = dz;
      it.cx = cx; it.cy = cy; it.cz = cz;
      it.r  = r[CW-2:0];
      return it;
   endfunction

   // Ray aimed at a sphere placed somewhere along it, with some jitter.
   function automatic ray_item_type aimed_ray();
      ray_item_type it;
      int k;
      k = $urandom_range(0, 100) - 10;
      it.ox = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
      it.oy = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
      it.oz = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
      it.dx = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
      it.dy = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
      it.dz = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
      it.cx = it.ox + it.dx * k + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      it.cy = it.oy + it.dy * k + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      it.cz = it.oz + it.dz * k + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      it.r  = (CW-1)'($urandom_range(0, 1 << 22));
      return it;
   endfunction

   function automatic ray_item_type noise_ray();
      ray_item_type it;
      it.ox = $urandom; it.oy = $urandom; it.oz = $urandom;
      it.dx = $urandom; it.dy = $urandom; it.dz = $urandom;
      it.cx = $urandom; it.cy = $urandom; it.cz = $urandom;
      it.r  = (CW-1)'($urandom);
      return it;
   endfunction

   // Fill the stimulus queue, then wait for the pipeline to drain and report.
   initial begin
      ray_item_type it;
      int one;
      one = 1 << FB;
      // zero direction: no hit whatever the sphere
      pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 0, 5 * one, 0, 0, one));
      // origin inside the sphere: only the far root is positive
      pending_rays.push_back(make_ray(0, 0, 0, one, 0, 0, 0, 0, 0, 2 * one));
      // plain hit in front, and the same sphere behind the ray
      pending_rays.push_back(make_ray(0, 0, 0, 0, 0, one, 0, 0, 10 * one, one));
      pending_rays.push_back(make_ray(0, 0, 0, 0, 0, -one, 0, 0, 10 * one, one));
      // clear miss: negative discriminant
      pending_rays.push_back(make_ray(0, 0, 0, one, 0, 0, 0, 10 * one, 0, one));
      // grazing tangent
      pending_rays.push_back(make_ray(0, one, 0, one, 0, 0, 10 * one, 0, 0, one));
      // tiny roots below one LSB
      pending_rays.push_back(make_ray(0, 0, 0, 32'h7fff_ffff, 0, 0, 1, 0, 0, 0));
      pending_rays.push_back(make_ray(0, 0, 0, -32'sh8000_0000, 0, 0, -1, 0, 0, 1));
      // huge distance: tiny direction, far sphere, saturates
      pending_rays.push_back(make_ray(-32'sh8000_0000, 0, 0, 1, 0, 0, 32'h7fff_0000, 0, 0,
                                      one));
      // zero radius sphere on the ray
      pending_rays.push_back(make_ray(0, 0, 0, one, one, one, 3 * one, 3 * one, 3 * one, 0));
      // field extremes everywhere
      pending_rays.push_back(make_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                      -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
                                      -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
                                      32'h7fff_ffff));
      pending_rays.push_back(make_ray(-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
                                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                      32'h7fff_ffff));
      pending_rays.push_back(make_ray(-1, -1, -1, -1, -1, -1, 0, 0, 0, 32'h7fff_ffff));
      pending_rays.push_back(make_ray(0, 0, 0, -32'sh8000_0000, 0, 0, 0, 0, 0, 32'h7fff_ffff));
      // random part: mostly aimed rays, some pure noise
      repeat (950) begin
         if ($urandom_range(0, 3) != 0) it = aimed_ray();
         else it = noise_ray();
         pending_rays.push_back(it);
      end
      total_rays = pending_rays.size();

      wait (!reset);
      while (pending_rays.size() != 0 || req_valid || expected_hits.size() != 0)
         @(posedge clock);
      repeat (120) @(posedge clock);
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   initial begin
      reset = 1;
      repeat (6) @(posedge clock);
      reset <= 0;
   end

   // Abort on a hung handshake.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Driver: present one beat at a time, hold it until accepted, idle in bursts.
   int req_gap = 0;
   initial begin
      req_valid = 0;
      req_origin_x = 0; req_origin_y = 0; req_origin_z = 0;
      req_dir_x = 0; req_dir_y = 0; req_dir_z = 0;
      req_center_x = 0; req_center_y = 0; req_center_z = 0;
      req_radius = 0;
   end

   always @(posedge clock) begin
      ray_item_type it;
      if (!reset) begin
         if (req_valid && req_ready) begin
            it = make_ray(req_origin_x, req_origin_y, req_origin_z, req_dir_x, req_dir_y,
                          req_dir_z, req_center_x, req_center_y, req_center_z,
                          {1'b0, req_radius});
            expected_hits.push_back(predict_nearest_hit(it));
            beats_sent++;
            if (beats_sent > total_rays - 120) quiet = 1;
         end
         // hold an unaccepted beat; otherwise idle or advance to the next one
         if (!(req_valid && !req_ready)) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 0;
            end else if (pending_rays.size() != 0 && !quiet && $urandom_range(0, 5) == 0) begin
               req_gap = $urandom_range(1, 11) - 1;
               req_valid <= 0;
            end else if (pending_rays.size() != 0) begin
               it = pending_rays.pop_front();
               req_origin_x <= it.ox; req_origin_y <= it.oy; req_origin_z <= it.oz;
               req_dir_x <= it.dx; req_dir_y <= it.dy; req_dir_z <= it.dz;
               req_center_x <= it.cx; req_center_y <= it.cy; req_center_z <= it.cz;
               req_radius <= it.r;
               req_valid <= 1;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // Monitor: check each result beat against the oldest prediction; stall in bursts.
   int rsp_stall = 0;
   initial rsp_ready = 0;

   always @(posedge clock) begin
      hit_result_type exp_hit;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_hits.size() == 0) begin
               $error("result beat with nothing expected: hit %0d distance %0h",
                      rsp_hit, rsp_distance);
               errors++;
            end else begin
               exp_hit = expected_hits.pop_front();
               if (rsp_hit !== exp_hit.hit) begin
                  $error("hit: expected %0d actual %0d", exp_hit.hit, rsp_hit);
                  errors++;
               end
               if (rsp_distance !== exp_hit.distance) begin
                  $error("distance: expected %0h actual %0h", exp_hit.distance,
                         rsp_distance);
                  errors++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= (rsp_stall == 0);
         end else if (!quiet && $urandom_range(0, 6) == 0) begin
            rsp_stall = $urandom_range(1, 11);
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

endmodule

>>> files.f
src/rsi_pkg.sv
src/rsi_isqrt.sv
src/rsi_divide.sv
src/ray_sphere_intersect.sv
tb/ray_sphere_intersect_tb.sv
